### hw/rtl/ashc_pkg.sv
`timescale 1ns / 1ps

package ashc_pkg;

  typedef enum logic {
    MODE_SOFT = 1'b0,
    MODE_HARD = 1'b1
  } clip_mode_t;

  // fixed datapath widths, set by the soft knee (|s| <= 3.0 in q3.12)
  localparam int MAG_W = 14;   // |s| <= 12288
  localparam int SQ_W  = 28;   // s^2
  localparam int KSQ_W = 30;   // k + s^2
  localparam int NUM_W = 45;   // 4*|s|*(k + s^2)
  localparam int DEN_W = 31;   // k + 9*s^2
  localparam int DIV_W = 46;   // 2*num + den
  localparam int DVS_W = 32;   // 2*den
  localparam int Q_W   = 15;   // rounded quotient, at most 16384
  localparam int OUT_W = 16;

  localparam int unsigned PADE_K = 32'd452984832;  // 27 * 2^24
  localparam int SOFT_KNEE = 12288;
  localparam int HARD_KNEE = 4096;
  localparam int OUT_ONE   = 16384;

endpackage

### hw/rtl/audio_soft_hard_clipper_unit.sv
`timescale 1ns / 1ps

// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// in       | in_valid / in_stall   | sample_in  (SAMPLE_WIDTH, signed q3.12)
// out      | out_valid / out_stall | sample_out (16, signed q1.14)
// config   | cfg_we                | cfg_wdata  (clip_mode, 1 bit)
//
// one item per cycle while in_stall is low
// the pipeline has 4 operand stages, 15 divider stages (one quotient bit each) and the output register
// rst is synchronous: clears the pipeline valid bits, skid buffer and clip_mode
// a stall on out parks one item in a skid register; in_stall follows that register
// so the pipeline freezes while that register is full and no item is lost or repeated

module audio_soft_hard_clipper_unit
  import ashc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [OUT_W-1:0]        sample_out
);

  localparam int EXT_W = (SAMPLE_WIDTH > OUT_W) ? SAMPLE_WIDTH : OUT_W;
  localparam int NST   = 4 + Q_W;

  localparam logic signed [EXT_W-1:0] SOFT_POS = EXT_W'(SOFT_KNEE);
  localparam logic signed [EXT_W-1:0] SOFT_NEG = -EXT_W'(SOFT_KNEE);
  localparam logic signed [EXT_W-1:0] HARD_POS = EXT_W'(HARD_KNEE);
  localparam logic signed [EXT_W-1:0] HARD_NEG = -EXT_W'(HARD_KNEE);
  localparam logic signed [OUT_W-1:0] ONE_POS  = OUT_W'(OUT_ONE);
  localparam logic signed [OUT_W-1:0] ONE_NEG  = -OUT_W'(OUT_ONE);

  clip_mode_t clip_mode;

  logic adv;
  logic v [NST];
  logic neg [NST];
  logic byp [NST];
  logic [OUT_W-1:0] bypv [NST];

  logic [MAG_W-1:0] mag_a;
  logic [MAG_W-1:0] mag_b;
  logic [SQ_W-1:0]  sq_b;
  logic [NUM_W-1:0] num_c;
  logic [DEN_W-1:0] den_c;
  logic [DIV_W-1:0] rem [Q_W+1];
  logic [DVS_W-1:0] dvs [Q_W+1];
  logic [Q_W-1:0]   quo [Q_W+1];

  logic ov;
  logic [OUT_W-1:0] od;
  logic skv;
  logic [OUT_W-1:0] skd;

  // stage 0 front end
  logic signed [EXT_W-1:0] s_ext;
  logic [EXT_W-1:0]        s_abs;
  logic                    neg_next;
  logic                    byp_next;
  logic [OUT_W-1:0]        bypv_next;
  logic [MAG_W-1:0]        mag_next;

  always_comb begin
    s_ext    = EXT_W'(sample_in);
    neg_next = s_ext < 0;
    s_abs    = neg_next ? EXT_W'(-s_ext) : EXT_W'(s_ext);
    mag_next = s_abs[MAG_W-1:0];
    byp_next = 1'b1;
    unique case (clip_mode)
      MODE_HARD: begin
        if (s_ext > HARD_POS) begin
          bypv_next = ONE_POS;
        end else if (s_ext < HARD_NEG) begin
          bypv_next = ONE_NEG;
        end else begin
          bypv_next = {s_ext[MAG_W-1:0], 2'b00};
        end
      end
      MODE_SOFT: begin
        if (s_ext > SOFT_POS) begin
          bypv_next = ONE_POS;
        end else if (s_ext < SOFT_NEG) begin
          bypv_next = ONE_NEG;
        end else begin
          bypv_next = '0;
          byp_next  = 1'b0;
        end
      end
      default: begin
        bypv_next = '0;
        byp_next  = 1'b0;
      end
    endcase
  end

  // stage 1: square, stage 2: numerator and denominator, stage 3: divider operands
  logic [SQ_W-1:0]  sq_next;
  logic [KSQ_W-1:0] ksq;
  logic [NUM_W-1:0] prod;
  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;
  logic [DIV_W-1:0] dividend_next;
  logic [DVS_W-1:0] divisor_next;

  always_comb begin
    sq_next       = SQ_W'(mag_a) * SQ_W'(mag_a);
    ksq           = KSQ_W'(PADE_K) + KSQ_W'(sq_b);
    prod          = NUM_W'(ksq) * NUM_W'(mag_b);
    num_next      = prod << 2;
    den_next      = DEN_W'(PADE_K) + (DEN_W'(sq_b) << 3) + DEN_W'(sq_b);
    // (2*num + den) / (2*den) gives round half up on the magnitude
    dividend_next = {num_c, 1'b0} + DIV_W'(den_c);
    divisor_next  = {den_c, 1'b0};
  end

  assign adv      = !skv;
  assign in_stall = skv;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_mode <= MODE_SOFT;
    end else if (cfg_we) begin
      clip_mode <= clip_mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        v[k] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg[0]  <= neg_next;
      byp[0]  <= byp_next;
      bypv[0] <= bypv_next;
      for (int k = 1; k < NST; k++) begin
        neg[k]  <= neg[k-1];
        byp[k]  <= byp[k-1];
        bypv[k] <= bypv[k-1];
      end
      mag_a  <= mag_next;
      mag_b  <= mag_a;
      sq_b   <= sq_next;
      num_c  <= num_next;
      den_c  <= den_next;
      rem[0] <= dividend_next;
      dvs[0] <= divisor_next;
      quo[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    localparam int SH = Q_W - k;
    logic [DIV_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = DIV_W'(dvs[k-1]) << SH;
      take  = rem[k-1] >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= take ? rem[k-1] - trial : rem[k-1];
        dvs[k] <= dvs[k-1];
        quo[k] <= {quo[k-1][Q_W-2:0], take};
      end
    end
  end

  // sign and saturate at the tail, or pass the bypass value
  logic [Q_W-1:0]   q_sat;
  logic [OUT_W-1:0] res_mag;
  logic [OUT_W-1:0] res;

  always_comb begin
    q_sat   = (quo[Q_W] > Q_W'(OUT_ONE)) ? Q_W'(OUT_ONE) : quo[Q_W];
    res_mag = OUT_W'(q_sat);
    if (byp[NST-1]) begin
      res = bypv[NST-1];
    end else if (neg[NST-1]) begin
      res = -res_mag;
    end else begin
      res = res_mag;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      skv <= 1'b0;
    end else if (!ov || !out_stall) begin
      ov  <= skv || (adv && v[NST-1]);
      skv <= 1'b0;
    end else if (adv && v[NST-1]) begin
      skv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || !out_stall) begin
      od <= skv ? skd : res;
    end
    if (adv && ov && out_stall) begin
      skd <= res;
    end
  end

  assign out_valid  = ov;
  assign sample_out = od;

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    skv |-> $past(ov && out_stall))
    else $error("skid entry held without an output stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_stall) |=> !skv)
    else $error("skid entry not drained after output transfer");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(sample_out) <= ONE_POS && $signed(sample_out) >= ONE_NEG))
    else $error("output sample beyond unity");

  a_frozen_when_skid: assert property (@(posedge clk) disable iff (rst)
    skv |=> $stable(v[NST-1]))
    else $error("pipeline moved while skid entry full");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

import ashc_pkg::*;

class clip_scoreboard;
  clip_mode_t mode;
  logic signed [OUT_W-1:0] expected_out[$];
  int errors;

  function new();
    mode = MODE_SOFT;
    errors = 0;
  endfunction

  // soft: pade tanh on the magnitude, round half away from zero, saturate
  // hard: clamp to +-1.0 then rescale q3.12 -> q1.14
  function logic signed [OUT_W-1:0] clip_sample(logic signed [15:0] s);
    longint sv;
    longint unsigned mag, sq, num, den, q;
    longint y;
    sv = s;
    if (mode == MODE_HARD) begin
      if (sv > HARD_KNEE) sv = HARD_KNEE;
      if (sv < -HARD_KNEE) sv = -HARD_KNEE;
      y = sv * 4;
    end else if (sv > SOFT_KNEE) begin
      y = OUT_ONE;
    end else if (sv < -SOFT_KNEE) begin
      y = -OUT_ONE;
    end else begin
      mag = (sv < 0) ? -sv : sv;
      sq = mag * mag;
      num = 4 * mag * (PADE_K + sq);
      den = PADE_K + 9 * sq;
      q = (2 * num + den) / (2 * den);
      if (q > OUT_ONE) q = OUT_ONE;
      y = (sv < 0) ? -longint'(q) : longint'(q);
    end
    return y[OUT_W-1:0];
  endfunction

  function void note_sample(logic signed [15:0] s);
    expected_out.push_back(clip_sample(s));
  endfunction

  function void check_sample(logic signed [OUT_W-1:0] actual);
    logic signed [OUT_W-1:0] want;
    if (expected_out.size() == 0) begin
      $display("%0t: unexpected sample_out, expected none, actual %0d", $time, actual);
      errors++;
    end else begin
      want = expected_out.pop_front();
      if (actual !== want) begin
        $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_out.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SEGMENT_ITEMS = 140;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] sample_in;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] sample_out;

  clip_scoreboard clip_sb;
  int in_gap_pct;
  int out_gap_pct;
  int hold_left;
  logic hold_start;
  logic hold_done;
  int cycle_count;

  logic signed [15:0] corner_samples[12] = '{
    -16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, 16'sd4096,
    -16'sd4097, 16'sd12288, -16'sd12288, 16'sd12289, -16'sd12289, 16'sd12287
  };

  audio_soft_hard_clipper_unit #(.SAMPLE_WIDTH(16)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output side: check accepted items, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) clip_sb.check_sample(sample_out);
    if (hold_start && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_gap_pct);
    end
  end

  function automatic logic signed [15:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = int'($urandom_range(24576)) - 12288;
    end else if (sel < 55) begin
      // around the hard and soft knees
      v = ($urandom_range(1) ? 12288 : 4096) + int'($urandom_range(6)) - 3;
      if ($urandom_range(1)) v = -v;
    end else if (sel < 70) begin
      v = int'($urandom_range(126)) - 63;
    end else begin
      v = $urandom;
    end
    return v[15:0];
  endfunction

  task automatic send_sample(input logic signed [15:0] s);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      sample_in <= 16'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (clip_sb.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_mode(input clip_mode_t m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    clip_sb.mode = m;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    sample_in = '0;
    out_stall = 1'b0;
    hold_left = 0;
    hold_start = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    in_gap_pct = 11;
    out_gap_pct = 69;
    clip_sb = new();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(MODE_SOFT);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    write_mode(MODE_HARD);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);

    write_mode(MODE_SOFT);
    send_random(SEGMENT_ITEMS);
    write_mode(MODE_HARD);
    send_random(SEGMENT_ITEMS);

    in_gap_pct = 69;
    out_gap_pct = 11;
    send_random(SEGMENT_ITEMS);
    write_mode(MODE_SOFT);
    send_random(SEGMENT_ITEMS);

    in_gap_pct = 0;
    out_gap_pct = 0;
    // long receiver hold-off so the pipe fills and backs up the input
    hold_start <= 1'b1;
    send_random(SEGMENT_ITEMS);
    write_mode(MODE_HARD);
    send_random(SEGMENT_ITEMS);

    drain();
    repeat (40) @(posedge clk);
    if (clip_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
